// ----- rtl/tabular_q_learning_engine_core_defines.svh -----
// Assertion macros shared by the checker.
`ifndef TABULAR_Q_LEARNING_ENGINE_CORE_DEFINES_SVH
`define TABULAR_Q_LEARNING_ENGINE_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is low
`define TQLE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define TQLE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/tqle_pkg.sv -----
`default_nettype none
package tqle_pkg;

  // Grid and table geometry
  localparam int GRID_SIDE = 8;
  localparam int COORD_W   = 3;
  localparam int CELLS     = GRID_SIDE * GRID_SIDE;
  localparam int CELL_W    = $clog2(CELLS);
  localparam int N_ACT     = 4;
  localparam int ACT_W     = 2;
  localparam int Q_W       = 16;
  localparam int ROW_W     = N_ACT * Q_W;

  // Configuration registers
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 9;
  localparam int RATE_W     = 9;
  localparam int EXPLORE_W  = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN_RATE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE    = 2'd2;
  localparam logic [RATE_W-1:0]    LEARN_RATE_RST = 9'd128;
  localparam logic [RATE_W-1:0]    DISCOUNT_RST   = 9'd230;
  localparam logic [EXPLORE_W-1:0] EXPLORE_RST    = 7'd50;

  // Commands
  localparam logic CMD_CHOOSE = 1'b0;
  localparam logic CMD_UPDATE = 1'b1;

  // Update arithmetic widths
  localparam int T_W    = 27;                 // reward + discount*M - 256*Q
  localparam int P_W    = T_W + RATE_W + 1;   // signed product
  localparam int FRAC_W = 16;                 // learn_rate and discount fractions
  localparam int S_W    = P_W - FRAC_W;       // step after the shift
  localparam int SUM_W  = S_W + 1;            // old value plus step

  localparam logic signed [Q_W-1:0] GREEDY_FLOOR = -16'sd1000;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_A,
    ST_READ_B,
    ST_MUL_DISC,
    ST_MUL_LR,
    ST_STEP,
    ST_DONE
  } tqle_state_t;

  typedef struct packed {
    logic                    cmd;
    logic [COORD_W-1:0]      cell_x;
    logic [COORD_W-1:0]      cell_y;
    logic [ACT_W-1:0]        action;
    logic [COORD_W-1:0]      next_x;
    logic [COORD_W-1:0]      next_y;
    logic signed [Q_W-1:0]   reward;
    logic [EXPLORE_W-1:0]    random_draw;
    logic [ACT_W-1:0]        random_action;
  } tqle_in_t;

  typedef struct packed {
    logic [ACT_W-1:0]        chosen_action;
    logic                    explored;
    logic signed [Q_W-1:0]   q_value;
  } tqle_out_t;

  // Sequencer controls toward the datapath
  typedef struct packed {
    logic idle;
    logic rd_en;
    logic rd_from_in;
    logic ld_choose;
    logic ld_m;
    logic ld_q;
    logic mul_en;
    logic mul_lr;
    logic ld_t;
    logic wr_en;
    logic ld_update;
    logic ld_out;
  } tqle_ctl_t;

  typedef struct packed {
    logic [ACT_W-1:0]      pick;
    logic signed [Q_W-1:0] value;
  } tqle_greedy_t;

  // Clamp a coordinate into the grid
  function automatic logic [COORD_W-1:0] clamp_coord(input logic [COORD_W-1:0] c);
    if (int'(c) >= GRID_SIDE) begin
      return COORD_W'(GRID_SIDE - 1);
    end
    return c;
  endfunction

  // Table row for a cell
  function automatic logic [CELL_W-1:0] cell_index(input logic [COORD_W-1:0] x,
                                                   input logic [COORD_W-1:0] y);
    return CELL_W'(int'(clamp_coord(y)) * GRID_SIDE + int'(clamp_coord(x)));
  endfunction

  // One action value out of a row
  function automatic logic signed [Q_W-1:0] row_lane(input logic [ROW_W-1:0] row,
                                                     input logic [ACT_W-1:0] act);
    return row[act*Q_W +: Q_W];
  endfunction

  // First value strictly above the running best, starting at the floor
  function automatic tqle_greedy_t greedy_pick(input logic [ROW_W-1:0] row);
    tqle_greedy_t          g;
    logic signed [Q_W-1:0] best;
    logic signed [Q_W-1:0] v;
    best    = GREEDY_FLOOR;
    g.pick  = '0;
    g.value = row[Q_W-1:0];
    for (int a = 0; a < N_ACT; a++) begin
      v = row[a*Q_W +: Q_W];
      if (v > best) begin
        best    = v;
        g.pick  = ACT_W'(a);
        g.value = v;
      end
    end
    return g;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/tqle_ram.sv -----
`default_nettype none
module tqle_ram #(
  parameter int WIDTH  = 64,
  parameter int DEPTH  = 64,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  wire logic              clk,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] waddr,
  input  wire logic [WIDTH-1:0]  wdata,
  input  wire logic              re,
  input  wire logic [ADDR_W-1:0] raddr,
  output logic      [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tqle_mul.sv -----
`default_nettype none
module tqle_mul (
  input  wire logic                                clk,
  input  wire logic                                en,
  input  wire logic signed [tqle_pkg::T_W-1:0]     a,
  input  wire logic        [tqle_pkg::RATE_W-1:0]  b,
  output logic signed      [tqle_pkg::P_W-1:0]     p
);
  import tqle_pkg::*;

  logic signed [RATE_W:0] b_s;

  // Unsigned factor as a non-negative signed operand
  assign b_s = $signed({1'b0, b});

  // Shared multiplier, product registered
  always_ff @(posedge clk) begin
    if (en) begin
      p <= P_W'(a * b_s);
    end
  end

endmodule
`default_nettype wire

// ----- rtl/tqle_seq.sv -----
`default_nettype none
module tqle_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  input  wire logic                is_update,
  input  wire logic                out_free,
  output tqle_pkg::tqle_ctl_t      ctl
);
  import tqle_pkg::*;

  tqle_state_t state_r;
  tqle_state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_READ_A;
      ST_READ_A:   state_nxt = is_update ? ST_READ_B : ST_DONE;
      ST_READ_B:   state_nxt = ST_MUL_DISC;
      ST_MUL_DISC: state_nxt = ST_MUL_LR;
      ST_MUL_LR:   state_nxt = ST_STEP;
      ST_STEP:     state_nxt = ST_DONE;
      ST_DONE:     if (out_free) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctl = '0;
    case (state_r)
      ST_IDLE: begin
        ctl.idle       = 1'b1;
        ctl.rd_from_in = 1'b1;
        ctl.rd_en      = in_valid;
      end
      ST_READ_A: begin
        ctl.ld_choose = !is_update;
        ctl.ld_m      = is_update;
        ctl.rd_en     = is_update;
      end
      ST_READ_B: begin
        ctl.ld_q   = 1'b1;
        ctl.mul_en = 1'b1;
      end
      ST_MUL_DISC: begin
        ctl.ld_t = 1'b1;
      end
      ST_MUL_LR: begin
        ctl.mul_en = 1'b1;
        ctl.mul_lr = 1'b1;
      end
      ST_STEP: begin
        ctl.wr_en     = 1'b1;
        ctl.ld_update = 1'b1;
      end
      ST_DONE: begin
        ctl.ld_out = out_free;
      end
      default: ctl = '0;
    endcase
  end

endmodule
`default_nettype wire

// ----- rtl/tabular_q_learning_engine_core.sv -----
// Channel  | ports                          | direction | item
// ---------+--------------------------------+-----------+--------------------------------
// in       | in_valid, in_stall, in_data    | into core | one choose or update command
// out      | out_valid, out_stall, out_data | out core  | one result per command
// cfg      | cfg_we, cfg_idx, cfg_wdata     | into core | write of one config register
//
// Choose: READ_A loads the result from the row read, then DONE loads the output register.
// Update: READ_B, MUL_DISC, MUL_LR and STEP lie between, for two row reads on the table's
// one read port and two passes through the shared multiplier. One item is in work at a time;
// the next is taken once the result sits in the output register, even while out_stall
// holds it, and a later result waits in its last state until that register frees.
// Reset is synchronous: all cells read as zero through per-row valid bits, no clearing pass.
`default_nettype none
module tabular_q_learning_engine_core (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire tqle_pkg::tqle_in_t                in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output tqle_pkg::tqle_out_t                    out_data,
  input  wire logic                              cfg_we,
  input  wire logic [tqle_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  wire logic [tqle_pkg::CFG_DATA_W-1:0]   cfg_wdata
);
  import tqle_pkg::*;

  tqle_ctl_t             ctl;
  logic                  out_free;
  logic                  in_acc;

  logic [RATE_W-1:0]     learn_rate_r;
  logic [RATE_W-1:0]     discount_r;
  logic [EXPLORE_W-1:0]  explore_r;

  tqle_in_t              item_r;
  logic [CELL_W-1:0]     cell_addr;
  logic [CELL_W-1:0]     rd_addr;
  logic [ROW_W-1:0]      rd_data;
  logic [CELLS-1:0]      row_vld_r;
  logic                  rd_vld_r;
  logic [ROW_W-1:0]      row;
  tqle_greedy_t          g;
  logic                  explore;
  logic [ACT_W-1:0]      ch_pick;

  logic signed [Q_W-1:0] m_r;
  logic signed [Q_W-1:0] q_r;
  logic [ROW_W-1:0]      row_r;
  logic signed [T_W-1:0] t_r;
  logic signed [T_W-1:0] t_nxt;
  logic signed [T_W-1:0] mul_a;
  logic [RATE_W-1:0]     mul_b;
  logic signed [P_W-1:0] prod;
  logic signed [P_W-1:0] prod_adj;
  logic signed [S_W-1:0] step;
  logic signed [SUM_W-1:0] sum;
  logic signed [Q_W-1:0] nv;
  logic [ROW_W-1:0]      new_row;

  tqle_out_t             res_r;
  logic                  out_valid_r;
  tqle_out_t             out_data_r;

  // Handshake
  assign in_stall = !ctl.idle;
  assign in_acc   = in_valid && ctl.idle;
  assign out_free = !out_valid_r || !out_stall;

  tqle_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .is_update (item_r.cmd == CMD_UPDATE),
    .out_free  (out_free),
    .ctl       (ctl)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      learn_rate_r <= LEARN_RATE_RST;
      discount_r   <= DISCOUNT_RST;
      explore_r    <= EXPLORE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_LEARN_RATE: learn_rate_r <= cfg_wdata[RATE_W-1:0];
        CFG_DISCOUNT:   discount_r   <= cfg_wdata[RATE_W-1:0];
        CFG_EXPLORE:    explore_r    <= cfg_wdata[EXPLORE_W-1:0];
        default:        ;
      endcase
    end
  end

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r <= in_data;
    end
  end

  assign cell_addr = cell_index(item_r.cell_x, item_r.cell_y);

  // First read: next cell for updates, queried cell for choose; second read: updated cell
  always_comb begin
    if (ctl.rd_from_in) begin
      rd_addr = (in_data.cmd == CMD_UPDATE) ? cell_index(in_data.next_x, in_data.next_y)
                                            : cell_index(in_data.cell_x, in_data.cell_y);
    end else begin
      rd_addr = cell_addr;
    end
  end

  tqle_ram #(
    .WIDTH (ROW_W),
    .DEPTH (CELLS)
  ) u_table (
    .clk   (clk),
    .we    (ctl.wr_en),
    .waddr (cell_addr),
    .wdata (new_row),
    .re    (ctl.rd_en),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Row valid bits: an unwritten row reads as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
      rd_vld_r  <= 1'b0;
    end else begin
      if (ctl.wr_en) begin
        row_vld_r[cell_addr] <= 1'b1;
      end
      if (ctl.rd_en) begin
        rd_vld_r <= row_vld_r[rd_addr];
      end
    end
  end

  assign row     = rd_vld_r ? rd_data : '0;
  assign g       = greedy_pick(row);
  assign explore = item_r.random_draw < explore_r;
  assign ch_pick = explore ? item_r.random_action : g.pick;

  // Latch the next cell's best value, then the old value and its row, then the target term
  always_ff @(posedge clk) begin
    if (ctl.ld_m) begin
      m_r <= g.value;
    end
    if (ctl.ld_q) begin
      q_r   <= row_lane(row, item_r.action);
      row_r <= row;
    end
    if (ctl.ld_t) begin
      t_r <= t_nxt;
    end
  end

  // Shared multiplier: discount*M first, then learn_rate*T
  assign mul_a = ctl.mul_lr ? t_r : {{(T_W-Q_W){m_r[Q_W-1]}}, m_r};
  assign mul_b = ctl.mul_lr ? learn_rate_r : discount_r;

  tqle_mul u_mul (
    .clk (clk),
    .en  (ctl.mul_en),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  // Target term in 1/256 units
  assign t_nxt = {{(T_W-Q_W){item_r.reward[Q_W-1]}}, item_r.reward}
               + prod[T_W-1:0]
               - {{(T_W-8-Q_W){q_r[Q_W-1]}}, q_r, 8'b0};

  // Step truncated toward zero, then saturated sum
  assign prod_adj = prod + (prod[P_W-1] ? P_W'((1 << FRAC_W) - 1) : P_W'(0));
  assign step     = prod_adj[P_W-1:FRAC_W];
  assign sum      = {{(SUM_W-Q_W){q_r[Q_W-1]}}, q_r} + {step[S_W-1], step};

  always_comb begin
    if (sum[SUM_W-1:Q_W-1] == '0 || sum[SUM_W-1:Q_W-1] == '1) begin
      nv = sum[Q_W-1:0];
    end else if (sum[SUM_W-1]) begin
      nv = {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      nv = {1'b0, {(Q_W-1){1'b1}}};
    end
  end

  // Replace the updated lane in the row
  always_comb begin
    for (int a = 0; a < N_ACT; a++) begin
      new_row[a*Q_W +: Q_W] = (item_r.action == ACT_W'(a)) ? nv : row_r[a*Q_W +: Q_W];
    end
  end

  // Result of the item in work
  always_ff @(posedge clk) begin
    if (ctl.ld_choose) begin
      res_r.chosen_action <= ch_pick;
      res_r.explored      <= explore;
      res_r.q_value       <= row_lane(row, ch_pick);
    end else if (ctl.ld_update) begin
      res_r.chosen_action <= '0;
      res_r.explored      <= 1'b0;
      res_r.q_value       <= nv;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      out_data_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

// ----- rtl/tqle_checker.sv -----
`default_nettype none
`include "tabular_q_learning_engine_core_defines.svh"
module tqle_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_stall,
  input wire logic                              out_valid,
  input wire logic                              out_stall,
  input wire tqle_pkg::tqle_out_t               out_data
);
  import tqle_pkg::*;

  // Stalled result holds
  `TQLE_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")

  // One item at a time: busy right after an accept
  `TQLE_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && !in_stall, in_stall, "accepted a second item while busy")

  // No result appears in the cycle right after an accept
  `TQLE_ASSERT_NEXT(a_min_latency, clk, rst_n, in_valid && !in_stall, !$rose(out_valid), "result too early")

  // A fresh result frees the input side
  `TQLE_ASSERT_SAME(a_ready_on_result, clk, rst_n, $rose(out_valid), !in_stall, "not ready after result")

endmodule

bind tabular_q_learning_engine_core tqle_checker u_tqle_checker (.*);
`default_nettype wire

// ----- tb/tb_tabular_q_learning_engine_core.sv -----
module tb_tabular_q_learning_engine_core;
  timeunit 1ns;
  timeprecision 1ps;

  import tqle_pkg::*;

  localparam int CYCLE_LIMIT     = 200000;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES   = 8;

  localparam logic signed [Q_W-1:0] RWD_MAX = 16'sh7fff;
  localparam logic signed [Q_W-1:0] RWD_MIN = 16'sh8000;

  typedef logic signed [Q_W-1:0] qv_t;
  typedef enum logic {ROW_CMD, ROW_REG} row_kind_t;

  typedef struct {
    row_kind_t             kind;
    tqle_in_t              item;
    bit                    typed;
    tqle_out_t             want;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] wdata;
  } dir_row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  tqle_in_t  in_data;
  logic      out_valid;
  logic      out_stall;
  tqle_out_t out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // Shadow copy of the action values and registers
  qv_t                  q_values [CELLS][N_ACT];
  logic [RATE_W-1:0]    lr_q;
  logic [RATE_W-1:0]    disc_q;
  logic [EXPLORE_W-1:0] explore_q;

  tqle_out_t pending_results[$];
  dir_row_t  dir_rows[$];

  bit steady;
  int err_count;
  int cycles;
  int n_choose;
  int n_update;
  int n_explored;
  int n_results;

  tabular_q_learning_engine_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Table row of a cell, coordinates clamped into the grid
  function automatic int unsigned cell_row(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y);
    int unsigned cx;
    int unsigned cy;
    cx = (int'(x) >= GRID_SIDE) ? GRID_SIDE - 1 : int'(x);
    cy = (int'(y) >= GRID_SIDE) ? GRID_SIDE - 1 : int'(y);
    return cy * GRID_SIDE + cx;
  endfunction

  // First action strictly above the running best, starting at -1000
  function automatic logic [ACT_W-1:0] best_action(int unsigned c);
    int               best;
    logic [ACT_W-1:0] pick;
    best = -1000;
    pick = '0;
    for (int a = 0; a < N_ACT; a++) begin
      if (int'(q_values[c][a]) > best) begin
        best = int'(q_values[c][a]);
        pick = ACT_W'(a);
      end
    end
    return pick;
  endfunction

  // Work out the result of one command and apply its table write
  function automatic tqle_out_t apply_command(tqle_in_t it);
    int unsigned      c;
    int unsigned      nc;
    logic [ACT_W-1:0] pick;
    longint           m;
    longint           oldq;
    longint           term;
    longint           stepv;
    longint           nv;
    tqle_out_t        r;
    r = '0;
    c = cell_row(it.cell_x, it.cell_y);
    if (it.cmd == CMD_CHOOSE) begin
      if (it.random_draw < explore_q) begin
        pick       = it.random_action;
        r.explored = 1'b1;
      end else begin
        pick = best_action(c);
      end
      r.chosen_action = pick;
      r.q_value       = q_values[c][pick];
    end else begin
      nc    = cell_row(it.next_x, it.next_y);
      m     = longint'(q_values[nc][best_action(nc)]);
      oldq  = longint'(q_values[c][it.action]);
      term  = longint'(it.reward) + longint'(disc_q) * m - 256 * oldq;
      stepv = (longint'(lr_q) * term) / 65536;
      nv    = oldq + stepv;
      if (nv > 32767) nv = 32767;
      if (nv < -32768) nv = -32768;
      q_values[c][it.action] = nv[Q_W-1:0];
      r.q_value              = nv[Q_W-1:0];
    end
    return r;
  endfunction

  function automatic tqle_in_t choose_cmd(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                          logic [EXPLORE_W-1:0] draw, logic [ACT_W-1:0] ra);
    tqle_in_t it;
    it               = '0;
    it.cmd           = CMD_CHOOSE;
    it.cell_x        = x;
    it.cell_y        = y;
    it.random_draw   = draw;
    it.random_action = ra;
    return it;
  endfunction

  function automatic tqle_in_t update_cmd(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                                          logic [ACT_W-1:0] act, logic [COORD_W-1:0] nx,
                                          logic [COORD_W-1:0] ny, qv_t rw);
    tqle_in_t it;
    it        = '0;
    it.cmd    = CMD_UPDATE;
    it.cell_x = x;
    it.cell_y = y;
    it.action = act;
    it.next_x = nx;
    it.next_y = ny;
    it.reward = rw;
    return it;
  endfunction

  function automatic dir_row_t cmd_row(tqle_in_t it);
    dir_row_t r;
    r.kind  = ROW_CMD;
    r.item  = it;
    r.typed = 1'b0;
    r.want  = '0;
    r.idx   = '0;
    r.wdata = '0;
    return r;
  endfunction

  function automatic dir_row_t known_row(tqle_in_t it, logic [ACT_W-1:0] act, logic expl,
                                         qv_t q);
    dir_row_t r;
    r                    = cmd_row(it);
    r.typed              = 1'b1;
    r.want.chosen_action = act;
    r.want.explored      = expl;
    r.want.q_value       = q;
    return r;
  endfunction

  function automatic dir_row_t reg_row(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    dir_row_t r;
    r       = cmd_row('0);
    r.kind  = ROW_REG;
    r.idx   = idx;
    r.wdata = val;
    return r;
  endfunction

  // Random command; hot ones stay in one 2x2 block so values build up
  function automatic tqle_in_t rand_cmd(bit hot, logic [1:0] hx, logic [1:0] hy);
    logic [63:0] raw;
    tqle_in_t    it;
    raw    = {$urandom, $urandom};
    it     = raw[$bits(tqle_in_t)-1:0];
    it.cmd = ($urandom_range(0, 99) < 55) ? CMD_UPDATE : CMD_CHOOSE;
    if (hot) begin
      it.cell_x[2:1] = hx;
      it.cell_y[2:1] = hy;
      it.next_x[2:1] = hx;
      it.next_y[2:1] = hy;
    end
    if ($urandom_range(0, 9) != 0) begin
      it.random_draw = EXPLORE_W'($urandom_range(0, 99));
    end
    case ($urandom_range(0, 7))
      0: it.reward = RWD_MAX;
      1: it.reward = RWD_MIN;
      2: it.reward = Q_W'($urandom_range(0, 511)) - Q_W'(256);
      default: ;
    endcase
    return it;
  endfunction

  // Write one register and mirror it in the shadow copy
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = val;
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      CFG_LEARN_RATE: lr_q = val[RATE_W-1:0];
      CFG_DISCOUNT:   disc_q = val[RATE_W-1:0];
      CFG_EXPLORE:    explore_q = val[EXPLORE_W-1:0];
      default: ;
    endcase
  endtask

  // Hold off new items until every result is back and the core has settled
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one item after a random gap (none while steady) and record its result once accepted
  task automatic send_cmd(tqle_in_t it, bit typed, tqle_out_t want);
    int        gap;
    tqle_out_t pred;
    gap = steady ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data  = it;
    do @(posedge clk); while (in_stall);
    pred = apply_command(it);
    pending_results.push_back(typed ? want : pred);
    if (it.cmd == CMD_CHOOSE) n_choose++;
    else n_update++;
  endtask

  // Compare one accepted result with the oldest expected one
  task automatic check_result(tqle_out_t got);
    tqle_out_t want;
    n_results++;
    if (got.explored) n_explored++;
    if (pending_results.size() == 0) begin
      $error("result with nothing outstanding: action %0d explored %0d value %0d",
             got.chosen_action, got.explored, got.q_value);
      err_count++;
    end else begin
      want = pending_results.pop_front();
      if (got.chosen_action !== want.chosen_action) begin
        $error("chosen_action: expected %0d, got %0d", want.chosen_action, got.chosen_action);
        err_count++;
      end
      if (got.explored !== want.explored) begin
        $error("explored: expected %0d, got %0d", want.explored, got.explored);
        err_count++;
      end
      if (got.q_value !== want.q_value) begin
        $error("q_value: expected %0d, got %0d", want.q_value, got.q_value);
        err_count++;
      end
    end
  endtask

  // Result side: raise out_stall at random per item, except while steady, then take it
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      n = steady ? 0 : $urandom_range(0, 7);
      @(negedge clk);
      out_stall = (n != 0);
      if (n != 0) begin
        repeat (n) @(negedge clk);
        out_stall = 1'b0;
      end
      do @(posedge clk); while (!out_valid);
      check_result(out_data);
    end
  end

  initial begin
    logic [1:0]            hx;
    logic [1:0]            hy;
    logic [CFG_DATA_W-1:0] lr_plan   [N_PHASES];
    logic [CFG_DATA_W-1:0] disc_plan [N_PHASES];
    logic [CFG_DATA_W-1:0] ex_plan   [N_PHASES];
    lr_plan   = '{9'd128, 9'd0, 9'd256, 9'd511, 9'd200, 9'd511, 9'd0, 9'd256};
    disc_plan = '{9'd230, 9'd0, 9'd256, 9'd511, 9'd511, 9'd128, 9'd0, 9'd230};
    ex_plan   = '{9'd50,  9'd0, 9'd100, 9'd127, 9'd20,  9'd0,   9'd0, 9'd60};

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    steady    = 1'b0;
    err_count = 0;
    cycles    = 0;
    n_choose  = 0;
    n_update  = 0;
    n_explored = 0;
    n_results  = 0;
    foreach (q_values[c, a]) q_values[c][a] = '0;
    lr_q      = LEARN_RATE_RST;
    disc_q    = DISCOUNT_RST;
    explore_q = EXPLORE_RST;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values: greedy ties, explore threshold edges, draw above 99
    dir_rows.push_back(known_row(choose_cmd(0, 0, 99, 3), 0, 1'b0, 0));
    dir_rows.push_back(known_row(choose_cmd(7, 7, 0, 3), 3, 1'b1, 0));
    dir_rows.push_back(known_row(choose_cmd(3, 5, 49, 2), 2, 1'b1, 0));
    dir_rows.push_back(known_row(choose_cmd(5, 3, 50, 1), 0, 1'b0, 0));
    dir_rows.push_back(known_row(choose_cmd(7, 0, 127, 1), 0, 1'b0, 0));
    dir_rows.push_back(known_row(update_cmd(0, 0, 0, 7, 7, RWD_MAX), 0, 1'b0, 63));
    dir_rows.push_back(cmd_row(update_cmd(7, 7, 3, 0, 0, RWD_MIN)));
    dir_rows.push_back(cmd_row(choose_cmd(0, 0, 99, 1)));
    // No exploring, full learn rate, no discount
    dir_rows.push_back(reg_row(CFG_EXPLORE, 9'd0));
    dir_rows.push_back(reg_row(CFG_LEARN_RATE, 9'd256));
    dir_rows.push_back(reg_row(CFG_DISCOUNT, 9'd0));
    dir_rows.push_back(cmd_row(choose_cmd(7, 7, 0, 2)));
    dir_rows.push_back(known_row(update_cmd(1, 0, 1, 2, 0, RWD_MAX), 0, 1'b0, 127));
    // Registers above their nominal ranges
    dir_rows.push_back(reg_row(CFG_EXPLORE, 9'd127));
    dir_rows.push_back(reg_row(CFG_LEARN_RATE, 9'd511));
    dir_rows.push_back(reg_row(CFG_DISCOUNT, 9'd511));
    dir_rows.push_back(known_row(choose_cmd(1, 0, 126, 3), 3, 1'b1, 0));
    // Drive every action of one cell below -1000, then query it greedily
    for (int r = 0; r < 2; r++) begin
      for (int a = 0; a < N_ACT; a++) begin
        dir_rows.push_back(cmd_row(update_cmd(6, 6, ACT_W'(a), 6, 6, RWD_MIN)));
      end
    end
    dir_rows.push_back(cmd_row(choose_cmd(6, 6, 127, 1)));
    // Zero learn rate leaves the value alone
    dir_rows.push_back(reg_row(CFG_EXPLORE, 9'd100));
    dir_rows.push_back(reg_row(CFG_LEARN_RATE, 9'd0));
    dir_rows.push_back(reg_row(CFG_DISCOUNT, 9'd256));
    dir_rows.push_back(cmd_row(update_cmd(6, 6, 2, 1, 0, RWD_MAX)));
    dir_rows.push_back(known_row(choose_cmd(1, 0, 99, 0), 0, 1'b1, 0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_REG) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].wdata);
      end else begin
        send_cmd(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    // Random phases, each under its own register setting
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      if (p == 6) begin
        lr_plan[p]   = CFG_DATA_W'($urandom_range(0, 511));
        disc_plan[p] = CFG_DATA_W'($urandom_range(0, 511));
        ex_plan[p]   = CFG_DATA_W'($urandom_range(0, 127));
      end
      write_reg(CFG_LEARN_RATE, lr_plan[p]);
      write_reg(CFG_DISCOUNT, disc_plan[p]);
      write_reg(CFG_EXPLORE, ex_plan[p]);
      steady = (p == 2 || p == 5);
      hx     = 2'($urandom_range(0, 3));
      hy     = 2'($urandom_range(0, 3));
      for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
        if (p == 3 && i == ITEMS_PER_PHASE / 2) wait_drained();
        send_cmd(rand_cmd($urandom_range(0, 9) < 8, hx, hy), 1'b0, '0);
      end
    end

    // Drain and give the core time to show any stray result
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Sent %0d choose and %0d update items, %0d results checked, %0d explored.",
             n_choose, n_update, n_results, n_explored);
    $display("Rates and discount swept 0..511, explore percent 0..127, with and without gaps.");
    if (err_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
